// File: design/ffha_pkg.sv
package ffha_pkg;

	localparam int SIZE_W = 16;
	localparam int OWNER_W = 8;
	localparam int ADDR_W = 17;
	localparam int FREE_W = 18;
	localparam int SPLIT_SLACK = 4;

	typedef struct packed {
		logic               valid;
		logic               free;
		logic [SIZE_W-1:0]  size;
		logic [OWNER_W-1:0] owner;
	} header_t;

	localparam int HEADER_W = $bits(header_t);

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RELEASE = 2'd2,
		OP_MERGE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOFIT   = 3'd1,
		ST_ZERO    = 3'd2,
		ST_CORRUPT = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_R_RD,
		S_R_EV,
		S_A_RD,
		S_A_EV,
		S_A_WR,
		S_M_RD,
		S_M_EV,
		S_M_NX,
		S_C_RD,
		S_C_EV
	} state_t;

endpackage

// File: design/first_fit_heap_allocator.sv
// first-fit heap allocator, headers kept in one synchronous memory
// command channel: present operation, request_size, owner_id and release_address
// with start; the item is taken at an edge where start is high and busy is low.
// each item gives exactly one result: status, granted_address and free_bytes are
// valid in the single cycle that done is high, and must be taken then.
// per item: every header visit is a memory read plus an evaluate state. an item
// runs the operation's own walk (init: one header write; release: one visit;
// alloc: a visit per block passed plus a header write for the block taken, or a
// last check when the walk runs off the heap; merge: a visit per header, plus a
// read of the neighbor when the block is free and the neighbor lies inside the
// heap, and a merge visits the same block again) followed by a free-byte walk to
// the heap end or to an invalid header. done is registered, and busy is already
// low when it is high. headers are read one at a time from a memory with a
// registered read port. after reset the header memory is cleared one entry per
// cycle while busy stays high; offset zero then holds one free block spanning
// the heap.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEAP_BASE    = 0,
	parameter int HEADER_BYTES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] request_size,
	input  logic [7:0]  owner_id,
	input  logic [16:0] release_address,
	output logic        done,
	output logic [2:0]  status,
	output logic [16:0] granted_address,
	output logic [17:0] free_bytes
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int OW = ((AW > 17) ? AW : 17) + 1;
	localparam int SW = $clog2(HEAP_BYTES + 1);
	localparam int HW = ffha_pkg::HEADER_W;
	localparam logic [OW-1:0] HEAP_OFF = OW'(HEAP_BYTES);
	localparam logic [OW-1:0] HDR_OFF = OW'(HEADER_BYTES);
	localparam logic [OW-1:0] SLACK_OFF = OW'(HEADER_BYTES + ffha_pkg::SPLIT_SLACK);

	ffha_pkg::state_t  state_q, state_d;
	logic [OW-1:0]     off_q, off_d;
	logic [OW-1:0]     nx_q, nx_d;
	logic [SW-1:0]     steps_q, steps_d;
	logic [AW-1:0]     clr_q, clr_d;
	logic [15:0]       size_q, size_d;
	logic [7:0]        owner_q, owner_d;
	logic [2:0]        status_q, status_d;
	logic [16:0]       gaddr_q, gaddr_d;
	logic [17:0]       total_q, total_d;
	ffha_pkg::header_t h_q, h_d;
	logic              done_q, done_d;

	logic              we, re;
	logic [AW-1:0]     waddr, raddr;
	logic [HW-1:0]     wdata, rdata;
	ffha_pkg::header_t rh, init_hdr;

	logic [OW-1:0] rsize, ssize, nx_w, split_off, rel_off;
	logic          fit, split, nx_in;

	assign rh = ffha_pkg::header_t'(rdata);
	assign init_hdr = '{valid: 1'b1, free: 1'b1, size: 16'(HEAP_BYTES - HEADER_BYTES),
		owner: 8'd0};
	assign rsize = OW'(rh.size);
	assign ssize = OW'(size_q);
	assign nx_w = off_q + HDR_OFF + rsize;
	assign split_off = off_q + HDR_OFF + ssize;
	assign fit = rh.free && (rh.size >= size_q);
	assign split = rsize > (ssize + SLACK_OFF);
	assign nx_in = nx_w < HEAP_OFF;
	assign rel_off = OW'(release_address - 17'(HEADER_BYTES + HEAP_BASE));

	ffha_ram #(.WIDTH(HW), .DEPTH(HEAP_BYTES)) u_hdr_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		off_q <= off_d;
		nx_q <= nx_d;
		steps_q <= steps_d;
		size_q <= size_d;
		owner_q <= owner_d;
		status_q <= status_d;
		gaddr_q <= gaddr_d;
		total_q <= total_d;
		h_q <= h_d;
	end

	// next state and datapath
	always_comb begin
		state_d = state_q;
		off_d = off_q;
		nx_d = nx_q;
		steps_d = steps_q;
		clr_d = clr_q;
		size_d = size_q;
		owner_d = owner_q;
		status_d = status_q;
		gaddr_d = gaddr_q;
		total_d = total_q;
		h_d = h_q;
		done_d = 1'b0;
		unique case (state_q)
			ffha_pkg::S_CLEAR: begin
				clr_d = clr_q + 1'b1;
				if (clr_q == AW'(HEAP_BYTES - 1)) state_d = ffha_pkg::S_IDLE;
			end
			ffha_pkg::S_IDLE: begin
				if (start) begin
					size_d = request_size;
					owner_d = owner_id;
					status_d = ffha_pkg::ST_OK;
					gaddr_d = '0;
					total_d = '0;
					steps_d = '0;
					off_d = '0;
					unique case (ffha_pkg::op_t'(operation))
						ffha_pkg::OP_INIT: state_d = ffha_pkg::S_INIT;
						ffha_pkg::OP_ALLOC: begin
							if (request_size == 16'd0) begin
								status_d = ffha_pkg::ST_ZERO;
								state_d = ffha_pkg::S_C_RD;
							end else begin
								state_d = ffha_pkg::S_A_RD;
							end
						end
						ffha_pkg::OP_RELEASE: begin
							if ({1'b0, release_address} < 18'(HEAP_BASE + HEADER_BYTES)) begin
								status_d = ffha_pkg::ST_IGNORED;
								state_d = ffha_pkg::S_C_RD;
							end else begin
								off_d = rel_off;
								state_d = ffha_pkg::S_R_RD;
							end
						end
						ffha_pkg::OP_MERGE: state_d = ffha_pkg::S_M_RD;
						default: state_d = ffha_pkg::S_IDLE;
					endcase
				end
			end
			ffha_pkg::S_INIT: state_d = ffha_pkg::S_C_RD;
			ffha_pkg::S_R_RD: begin
				if (off_q < HEAP_OFF) begin
					state_d = ffha_pkg::S_R_EV;
				end else begin
					status_d = ffha_pkg::ST_IGNORED;
					off_d = '0;
					state_d = ffha_pkg::S_C_RD;
				end
			end
			ffha_pkg::S_R_EV: begin
				if (!(rh.valid && !rh.free)) status_d = ffha_pkg::ST_IGNORED;
				off_d = '0;
				state_d = ffha_pkg::S_C_RD;
			end
			ffha_pkg::S_A_RD: begin
				if (off_q < HEAP_OFF) begin
					state_d = ffha_pkg::S_A_EV;
				end else begin
					status_d = ffha_pkg::ST_NOFIT;
					off_d = '0;
					state_d = ffha_pkg::S_C_RD;
				end
			end
			ffha_pkg::S_A_EV: begin
				if (!rh.valid) begin
					status_d = ffha_pkg::ST_CORRUPT;
					off_d = '0;
					state_d = ffha_pkg::S_C_RD;
				end else if (fit) begin
					h_d = '{valid: 1'b1, free: 1'b0, size: split ? size_q : rh.size,
						owner: owner_q};
					gaddr_d = 17'(HEAP_BASE) + 17'(off_q) + 17'(HEADER_BYTES);
					state_d = ffha_pkg::S_A_WR;
				end else begin
					off_d = nx_w;
					state_d = ffha_pkg::S_A_RD;
				end
			end
			ffha_pkg::S_A_WR: begin
				off_d = '0;
				state_d = ffha_pkg::S_C_RD;
			end
			ffha_pkg::S_M_RD: begin
				if (off_q < HEAP_OFF) begin
					state_d = ffha_pkg::S_M_EV;
				end else begin
					off_d = '0;
					state_d = ffha_pkg::S_C_RD;
				end
			end
			ffha_pkg::S_M_EV: begin
				h_d = rh;
				steps_d = steps_q + 1'b1;
				if (steps_q >= SW'(HEAP_BYTES) || !rh.valid) begin
					status_d = ffha_pkg::ST_CORRUPT;
					off_d = '0;
					state_d = ffha_pkg::S_C_RD;
				end else if (rh.free && nx_in) begin
					nx_d = nx_w;
					state_d = ffha_pkg::S_M_NX;
				end else begin
					off_d = nx_w;
					state_d = ffha_pkg::S_M_RD;
				end
			end
			ffha_pkg::S_M_NX: begin
				// on a merge the same offset is visited again
				if (!(rh.valid && rh.free)) off_d = nx_q;
				state_d = ffha_pkg::S_M_RD;
			end
			ffha_pkg::S_C_RD: begin
				if (off_q < HEAP_OFF) begin
					state_d = ffha_pkg::S_C_EV;
				end else begin
					done_d = 1'b1;
					state_d = ffha_pkg::S_IDLE;
				end
			end
			ffha_pkg::S_C_EV: begin
				if (!rh.valid) begin
					done_d = 1'b1;
					state_d = ffha_pkg::S_IDLE;
				end else begin
					if (rh.free) total_d = total_q + 18'(rh.size);
					off_d = nx_w;
					state_d = ffha_pkg::S_C_RD;
				end
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	// memory port drive
	always_comb begin
		we = 1'b0;
		waddr = off_q[AW-1:0];
		wdata = h_q;
		re = 1'b0;
		raddr = off_q[AW-1:0];
		unique case (state_q)
			ffha_pkg::S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == '0) ? init_hdr : '0;
			end
			ffha_pkg::S_INIT: begin
				we = 1'b1;
				waddr = '0;
				wdata = init_hdr;
			end
			ffha_pkg::S_R_RD, ffha_pkg::S_A_RD, ffha_pkg::S_M_RD, ffha_pkg::S_C_RD: begin
				re = off_q < HEAP_OFF;
			end
			ffha_pkg::S_R_EV: begin
				we = rh.valid && !rh.free;
				wdata = ffha_pkg::header_t'{valid: 1'b1, free: 1'b1, size: rh.size,
					owner: 8'd0};
			end
			ffha_pkg::S_A_EV: begin
				// split off the tail as a new free block
				we = rh.valid && fit && split && (split_off < HEAP_OFF);
				waddr = split_off[AW-1:0];
				wdata = ffha_pkg::header_t'{valid: 1'b1, free: 1'b1,
					size: 16'(rh.size - size_q - 16'(HEADER_BYTES)), owner: 8'd0};
			end
			ffha_pkg::S_A_WR: we = 1'b1;
			ffha_pkg::S_M_EV: begin
				re = steps_q < SW'(HEAP_BYTES) && rh.valid && rh.free && nx_in;
				raddr = nx_w[AW-1:0];
			end
			ffha_pkg::S_M_NX: begin
				we = rh.valid && rh.free;
				wdata = ffha_pkg::header_t'{valid: 1'b1, free: 1'b1,
					size: 16'(h_q.size + 16'(HEADER_BYTES) + rh.size), owner: h_q.owner};
			end
			default: ;
		endcase
	end

	assign busy = state_q != ffha_pkg::S_IDLE;
	assign done = done_q;
	assign status = status_q;
	assign granted_address = gaddr_q;
	assign free_bytes = total_q;

endmodule

// File: design/ffha_ram.sv
module ffha_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/sv/first_fit_heap_allocator_tb.sv
module first_fit_heap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP_BYTES   = 65536;
	localparam int HEAP_BASE    = 0;
	localparam int HEADER_BYTES = 6;
	localparam int N_RANDOM     = 1330;
	localparam int QUIET_TAIL   = 150;
	localparam longint CYCLE_LIMIT = 6000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [15:0] request_size;
	logic [7:0]  owner_id;
	logic [16:0] release_address;
	logic        done;
	logic [2:0]  status;
	logic [16:0] granted_address;
	logic [17:0] free_bytes;

	first_fit_heap_allocator #(
		.HEAP_BYTES(HEAP_BYTES),
		.HEAP_BASE(HEAP_BASE),
		.HEADER_BYTES(HEADER_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.request_size(request_size),
		.owner_id(owner_id),
		.release_address(release_address),
		.done(done),
		.status(status),
		.granted_address(granted_address),
		.free_bytes(free_bytes)
	);

	typedef struct {
		ffha_pkg::status_t st;
		logic [16:0]       addr;
		logic [17:0]       fb;
	} outcome_t;

	typedef struct {
		ffha_pkg::op_t     op;
		logic [15:0]       size;
		logic [7:0]        owner;
		logic [16:0]       raddr;
		bit                typed;
		ffha_pkg::status_t st;
		logic [16:0]       addr;
		logic [17:0]       fb;
	} row_t;

	// shadow heap: headers by offset, missing entries read as not valid
	ffha_pkg::header_t heap_hdr [int];
	outcome_t pending_q [$];
	int live_addr [$];
	int freed_addr [$];
	int errors;
	int items_sent;
	int n_granted;
	int n_corrupt;
	int n_released;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_q.size());
			$display("** first_fit_heap_allocator: FAILED **");
			$finish;
		end
	end

	task automatic mismatch(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic ffha_pkg::header_t hdr_get(input int off);
		ffha_pkg::header_t h;
		h = '0;
		if (off < HEAP_BYTES && heap_hdr.exists(off))
			h = heap_hdr[off];
		return h;
	endfunction

	function automatic void hdr_put(input int off, input bit is_free, input int size,
		input logic [7:0] owner);
		ffha_pkg::header_t h;
		h.valid = 1'b1;
		h.free = is_free;
		h.size = size[15:0];
		h.owner = owner;
		if (off < HEAP_BYTES)
			heap_hdr[off] = h;
	endfunction

	function automatic int free_sum();
		int total, off;
		ffha_pkg::header_t h;
		total = 0;
		off = 0;
		while (off < HEAP_BYTES) begin
			h = hdr_get(off);
			if (!h.valid)
				break;
			if (h.free)
				total += int'(h.size);
			off += HEADER_BYTES + int'(h.size);
		end
		return total;
	endfunction

	function automatic ffha_pkg::status_t heap_alloc(input int size, input logic [7:0] owner,
		output int addr);
		int off, hs;
		ffha_pkg::header_t h;
		addr = 0;
		if (size == 0)
			return ffha_pkg::ST_ZERO;
		off = 0;
		while (off < HEAP_BYTES) begin
			h = hdr_get(off);
			hs = int'(h.size);
			if (!h.valid)
				return ffha_pkg::ST_CORRUPT;
			if (h.free && hs >= size) begin
				if (hs > size + HEADER_BYTES + ffha_pkg::SPLIT_SLACK) begin
					hdr_put(off + HEADER_BYTES + size, 1'b1, hs - size - HEADER_BYTES, 8'd0);
					hs = size;
				end
				hdr_put(off, 1'b0, hs, owner);
				addr = (HEAP_BASE + off + HEADER_BYTES) & 17'h1ffff;
				return ffha_pkg::ST_OK;
			end
			off += HEADER_BYTES + hs;
		end
		return ffha_pkg::ST_NOFIT;
	endfunction

	function automatic ffha_pkg::status_t heap_release(input int addr);
		int off;
		ffha_pkg::header_t h;
		if (addr < HEAP_BASE + HEADER_BYTES)
			return ffha_pkg::ST_IGNORED;
		off = addr - HEADER_BYTES - HEAP_BASE;
		h = hdr_get(off);
		if (!h.valid || h.free)
			return ffha_pkg::ST_IGNORED;
		hdr_put(off, 1'b1, int'(h.size), 8'd0);
		return ffha_pkg::ST_OK;
	endfunction

	function automatic ffha_pkg::status_t heap_merge();
		int off, steps, nx;
		ffha_pkg::header_t h, n;
		off = 0;
		steps = 0;
		while (off < HEAP_BYTES) begin
			h = hdr_get(off);
			if (steps >= HEAP_BYTES)
				return ffha_pkg::ST_CORRUPT;
			steps++;
			if (!h.valid)
				return ffha_pkg::ST_CORRUPT;
			if (h.free) begin
				nx = off + HEADER_BYTES + int'(h.size);
				if (nx < HEAP_BYTES) begin
					n = hdr_get(nx);
					if (n.valid && n.free) begin
						// stay on this block, it may swallow the next one too
						hdr_put(off, 1'b1, int'(h.size) + HEADER_BYTES + int'(n.size),
							h.owner);
						continue;
					end
				end
			end
			off += HEADER_BYTES + int'(h.size);
		end
		return ffha_pkg::ST_OK;
	endfunction

	function automatic outcome_t heap_step(input ffha_pkg::op_t op, input logic [15:0] size,
		input logic [7:0] owner, input logic [16:0] raddr);
		outcome_t o;
		int a;
		a = 0;
		o.st = ffha_pkg::ST_OK;
		case (op)
			ffha_pkg::OP_INIT: hdr_put(0, 1'b1, HEAP_BYTES - HEADER_BYTES, 8'd0);
			ffha_pkg::OP_ALLOC: o.st = heap_alloc(int'(size), owner, a);
			ffha_pkg::OP_RELEASE: o.st = heap_release(int'(raddr));
			default: o.st = heap_merge();
		endcase
		o.addr = a[16:0];
		o.fb = 18'(free_sum());
		return o;
	endfunction

	// result checker: done marks a result for exactly one cycle
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				mismatch($sformatf("unexpected result status=%0d addr=%0d free=%0d",
					status, granted_address, free_bytes));
			end else begin
				e = pending_q.pop_front();
				if (status !== e.st)
					mismatch($sformatf("status %0d, expected %0d", status, e.st));
				if (granted_address !== e.addr)
					mismatch($sformatf("granted_address %0d, expected %0d",
						granted_address, e.addr));
				if (free_bytes !== e.fb)
					mismatch($sformatf("free_bytes %0d, expected %0d", free_bytes, e.fb));
			end
		end
	end

	// leaves start high; callers drop it before a gap
	task automatic issue(input row_t r);
		outcome_t o;
		start <= 1'b1;
		operation <= r.op;
		request_size <= r.size;
		owner_id <= r.owner;
		release_address <= r.raddr;
		do
			@(posedge clk);
		while (busy);
		o = heap_step(r.op, r.size, r.owner, r.raddr);
		if (r.typed) begin
			o.st = r.st;
			o.addr = r.addr;
			o.fb = r.fb;
		end
		pending_q.push_back(o);
		items_sent++;
		if (r.op == ffha_pkg::OP_ALLOC && o.st == ffha_pkg::ST_OK) begin
			n_granted++;
			live_addr.push_back(int'(o.addr));
		end
		if (o.st == ffha_pkg::ST_CORRUPT)
			n_corrupt++;
		if (r.op == ffha_pkg::OP_RELEASE && o.st == ffha_pkg::ST_OK)
			n_released++;
		if (r.op == ffha_pkg::OP_INIT)
			live_addr.delete();
	endtask

	task automatic maybe_gap(input bit allow);
		if (allow && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	function automatic row_t mk(input ffha_pkg::op_t op, input int size, input int owner,
		input int raddr);
		row_t r;
		r.op = op;
		r.size = size[15:0];
		r.owner = owner[7:0];
		r.raddr = raddr[16:0];
		r.typed = 1'b0;
		r.st = ffha_pkg::ST_OK;
		r.addr = '0;
		r.fb = '0;
		return r;
	endfunction

	function automatic row_t mkt(input ffha_pkg::op_t op, input int size, input int owner,
		input int raddr, input ffha_pkg::status_t st, input int addr, input int fb);
		row_t r;
		r = mk(op, size, owner, raddr);
		r.typed = 1'b1;
		r.st = st;
		r.addr = addr[16:0];
		r.fb = fb[17:0];
		return r;
	endfunction

	function automatic row_t random_row();
		row_t r;
		int pick, sz, k;
		pick = $urandom_range(0, 99);
		r = mk(ffha_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
		if (live_addr.size() > 30 || pick < 4) begin
			r.op = ffha_pkg::OP_INIT;
		end else if (pick < 50) begin
			r.op = ffha_pkg::OP_ALLOC;
			k = $urandom_range(0, 99);
			if (k < 2)
				sz = 0;
			else if (k < 72)
				sz = $urandom_range(1, 256);
			else if (k < 92)
				sz = $urandom_range(257, 4096);
			else
				sz = $urandom_range(4097, 65535);
			r.size = sz[15:0];
		end else if (pick < 82) begin
			r.op = ffha_pkg::OP_RELEASE;
			k = $urandom_range(0, 99);
			if (k < 75 && live_addr.size() > 0) begin
				sz = $urandom_range(0, live_addr.size() - 1);
				r.raddr = 17'(live_addr[sz]);
				freed_addr.push_back(live_addr[sz]);
				live_addr.delete(sz);
				if (freed_addr.size() > 16)
					void'(freed_addr.pop_front());
			end else if (k < 88 && freed_addr.size() > 0) begin
				// second release of the same block
				r.raddr = 17'(freed_addr[$urandom_range(0, freed_addr.size() - 1)]);
			end else if (k < 93) begin
				r.raddr = 17'($urandom_range(0, HEADER_BYTES));
			end
		end else if (pick < 96) begin
			r.op = ffha_pkg::OP_MERGE;
		end
		return r;
	endfunction

	initial begin
		row_t dir [$];
		row_t r;
		int i;
		errors = 0;
		items_sent = 0;
		n_granted = 0;
		n_corrupt = 0;
		n_released = 0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = ffha_pkg::OP_INIT;
		request_size = '0;
		owner_id = '0;
		release_address = '0;
		hdr_put(0, 1'b1, HEAP_BYTES - HEADER_BYTES, 8'd0);

		dir.push_back(mkt(ffha_pkg::OP_ALLOC, 0, 8'hff, 17'h1ffff, ffha_pkg::ST_ZERO, 0,
			65530));
		dir.push_back(mkt(ffha_pkg::OP_ALLOC, 65535, 8'h00, 0, ffha_pkg::ST_NOFIT, 0, 65530));
		dir.push_back(mkt(ffha_pkg::OP_RELEASE, 0, 0, 0, ffha_pkg::ST_IGNORED, 0, 65530));
		dir.push_back(mkt(ffha_pkg::OP_RELEASE, 0, 0, 5, ffha_pkg::ST_IGNORED, 0, 65530));
		dir.push_back(mkt(ffha_pkg::OP_RELEASE, 0, 0, 6, ffha_pkg::ST_IGNORED, 0, 65530));
		dir.push_back(mkt(ffha_pkg::OP_RELEASE, 0, 0, 17'h1ffff, ffha_pkg::ST_IGNORED, 0,
			65530));
		dir.push_back(mkt(ffha_pkg::OP_ALLOC, 100, 8'hff, 0, ffha_pkg::ST_OK, 6, 65424));
		dir.push_back(mkt(ffha_pkg::OP_RELEASE, 0, 0, 6, ffha_pkg::ST_OK, 0, 65524));
		dir.push_back(mkt(ffha_pkg::OP_MERGE, 0, 0, 0, ffha_pkg::ST_OK, 0, 65530));
		dir.push_back(mkt(ffha_pkg::OP_ALLOC, 65530, 8'h5a, 0, ffha_pkg::ST_OK, 6, 0));
		dir.push_back(mkt(ffha_pkg::OP_ALLOC, 1, 8'h01, 0, ffha_pkg::ST_NOFIT, 0, 0));
		dir.push_back(mkt(ffha_pkg::OP_RELEASE, 0, 0, 6, ffha_pkg::ST_OK, 0, 65530));
		dir.push_back(mkt(ffha_pkg::OP_RELEASE, 0, 0, 6, ffha_pkg::ST_IGNORED, 0, 65530));
		dir.push_back(mkt(ffha_pkg::OP_INIT, 0, 0, 0, ffha_pkg::ST_OK, 0, 65530));
		// surplus equal to header plus slack: no split
		dir.push_back(mkt(ffha_pkg::OP_ALLOC, 65520, 8'h10, 0, ffha_pkg::ST_OK, 6, 0));
		dir.push_back(mkt(ffha_pkg::OP_INIT, 0, 0, 0, ffha_pkg::ST_OK, 0, 65530));
		// one byte more surplus: the rest becomes a 5 byte free block
		dir.push_back(mkt(ffha_pkg::OP_ALLOC, 65519, 8'h20, 0, ffha_pkg::ST_OK, 6, 5));
		dir.push_back(mk(ffha_pkg::OP_INIT, 0, 0, 0));
		dir.push_back(mk(ffha_pkg::OP_ALLOC, 40000, 8'h33, 0));
		dir.push_back(mk(ffha_pkg::OP_ALLOC, 20000, 8'h44, 0));
		dir.push_back(mk(ffha_pkg::OP_RELEASE, 0, 0, 6));
		dir.push_back(mk(ffha_pkg::OP_RELEASE, 0, 0, 40012));
		// the three free blocks merge back into one block spanning the heap
		dir.push_back(mk(ffha_pkg::OP_MERGE, 0, 0, 0));
		dir.push_back(mk(ffha_pkg::OP_ALLOC, 8, 8'h77, 0));
		dir.push_back(mk(ffha_pkg::OP_INIT, 0, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir[k]) begin
			issue(dir[k]);
			maybe_gap(1'b1);
		end
		live_addr.delete();
		for (i = 0; i < N_RANDOM; i++) begin
			r = random_row();
			issue(r);
			maybe_gap(i < N_RANDOM - QUIET_TAIL);
		end
		start <= 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("%0d items: %0d blocks granted, %0d released, %0d broken-chain answers",
			items_sent, n_granted, n_released, n_corrupt);
		$display("%0d mismatches in %0d cycles", errors, cycles);
		if (errors == 0)
			$display("** first_fit_heap_allocator: PASSED **");
		else
			$display("** first_fit_heap_allocator: FAILED **");
		$finish;
	end
endmodule
